// File: hw/rtl/lik_pkg.sv
// Shared types, constants and helpers for the leg inverse kinematics block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lik_pkg;

  localparam int COORD_W      = 16;   // signed Q7.8 centimeters
  localparam int FRAC_BITS    = 8;
  localparam int MAG_W        = 34;   // unsigned magnitudes fed to the angle unit
  localparam int CORD_W       = 45;   // CORDIC x/y working width
  localparam int NORM_BIT     = 40;   // normalize until x or y reaches 2^40
  localparam int ANG_W        = 32;   // Q16 degrees, signed
  localparam int ANG_FRAC     = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_W       = 64;
  localparam int ROOT_W       = 32;
  localparam int LINK_W       = 6;
  localparam int REG_ADDR_W   = 5;
  localparam int REG_IDX_W    = 3;
  localparam int CMD_W        = 5;

  localparam int HEIGHT_RAISE = 4 << FRAC_BITS;

  localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] OFF_57  = ANG_W'(57 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] OFF_61  = ANG_W'(61 << ANG_FRAC);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LEFT_SIDE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRONT_PAIR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_MOUNT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_LINK = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_LINK = 3'd4;

  localparam logic [LINK_W-1:0] UPPER_LINK_RST = 6'd9;
  localparam logic [LINK_W-1:0] LOWER_LINK_RST = 6'd16;

  // datapath commands
  localparam logic [CMD_W-1:0] CMD_NOP      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_SET      = 5'd2;
  localparam logic [CMD_W-1:0] CMD_DIFF     = 5'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK    = 5'd4;
  localparam logic [CMD_W-1:0] CMD_CORD_HIP = 5'd5;
  localparam logic [CMD_W-1:0] CMD_GET_HIP  = 5'd6;
  localparam logic [CMD_W-1:0] CMD_MUL_XX   = 5'd7;
  localparam logic [CMD_W-1:0] CMD_MUL_YY   = 5'd8;
  localparam logic [CMD_W-1:0] CMD_MUL_HH   = 5'd9;
  localparam logic [CMD_W-1:0] CMD_MUL_LIM  = 5'd10;
  localparam logic [CMD_W-1:0] CMD_SUM      = 5'd11;
  localparam logic [CMD_W-1:0] CMD_PREP     = 5'd12;
  localparam logic [CMD_W-1:0] CMD_MUL_D1   = 5'd13;
  localparam logic [CMD_W-1:0] CMD_MUL_D2   = 5'd14;
  localparam logic [CMD_W-1:0] CMD_DIFF_D   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_SQRT_D   = 5'd16;
  localparam logic [CMD_W-1:0] CMD_GET_R    = 5'd17;
  localparam logic [CMD_W-1:0] CMD_SQRT_H   = 5'd18;
  localparam logic [CMD_W-1:0] CMD_GET_H    = 5'd19;
  localparam logic [CMD_W-1:0] CMD_CORD_B   = 5'd20;
  localparam logic [CMD_W-1:0] CMD_GET_B    = 5'd21;
  localparam logic [CMD_W-1:0] CMD_CORD_V   = 5'd22;
  localparam logic [CMD_W-1:0] CMD_GET_V    = 5'd23;
  localparam logic [CMD_W-1:0] CMD_CORD_P   = 5'd24;
  localparam logic [CMD_W-1:0] CMD_GET_P    = 5'd25;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 5'd26;
  localparam logic [CMD_W-1:0] CMD_PUSH     = 5'd27;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0] hip_angle;
    logic       hip_valid;
    logic [7:0] knee_angle;
    logic [7:0] foot_angle;
    logic       joints_valid;
  } out_item_t;

  typedef struct packed {
    logic              left_side;
    logic              front_pair;
    logic              edge_mount;
    logic [LINK_W-1:0] upper_link_cm;
    logic [LINK_W-1:0] lower_link_cm;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic is_move;
    logic hip_nz;
    logic reach;
    logic s_ok;
    logic d_ok;
    logic cord_busy;
    logic sqrt_busy;
    logic out_free;
  } status_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic [23:0] atan_deg(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:    v = 24'd2949120;
      5'd1:    v = 24'd1740967;
      5'd2:    v = 24'd919879;
      5'd3:    v = 24'd466945;
      5'd4:    v = 24'd234379;
      5'd5:    v = 24'd117304;
      5'd6:    v = 24'd58666;
      5'd7:    v = 24'd29335;
      5'd8:    v = 24'd14668;
      5'd9:    v = 24'd7334;
      5'd10:   v = 24'd3667;
      5'd11:   v = 24'd1833;
      5'd12:   v = 24'd917;
      5'd13:   v = 24'd458;
      5'd14:   v = 24'd229;
      5'd15:   v = 24'd115;
      5'd16:   v = 24'd57;
      5'd17:   v = 24'd29;
      5'd18:   v = 24'd14;
      5'd19:   v = 24'd7;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // Q16 degrees to whole degrees, truncated, clamped to 0..180
  function automatic logic [7:0] whole_deg(input logic signed [ANG_W-1:0] a);
    logic [ANG_W-ANG_FRAC-1:0] q;
    logic [7:0]                r;
    q = a[ANG_W-1:ANG_FRAC];
    if (a[ANG_W-1]) begin
      r = 8'd0;
    end else if (q > (ANG_W-ANG_FRAC)'(180)) begin
      r = 8'd180;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/leg_inverse_kinematics.sv
// Top level: register port, sequencer and datapath of the leg IK block.
// Depends on lik_pkg, lik_ctrl, lik_datapath (with lik_cordic, lik_isqrt).
//
// Usage
//   Input channel (in_valid_i/in_ready_o, in_data_i): one beat per item.
//   operation 0 stores the origin (z raised by 4 cm, saturating) and gives
//   no result; operation 1 is a move and gives exactly one result beat on
//   out_valid_o/out_ready_i, out_data_o.
//   One item at a time: in_ready_o is high only while the sequencer idles.
//   A move is shortest when the hip offset is zero and the target is out
//   of reach; on the full path it runs two square roots and up to four
//   atan runs, each a normalize shift followed by 20 CORDIC steps unless an input is zero.
//   The angle unit and the root unit are the pacing loops.
//   The result sits in an output register; a stalled receiver holds the
//   sequencer in its last state until the previous beat is taken, so the block
//   never drops or repeats a result.
//   Reset (rst_ni low, asynchronous) clears the origin to zero, loads the
//   register defaults (links 9 and 16 cm, flags 0) and empties the output.
//   Registers sit at 4*index on the APB-style port; pready is tied high.
`timescale 1ns / 1ps
`default_nettype none

module leg_inverse_kinematics (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lik_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lik_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lik_pkg::out_item_t             out_data_o
);

  lik_pkg::cfg_t    cfg_q;
  lik_pkg::cmd_t    cmd;
  lik_pkg::status_t status;

  logic [lik_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lik_pkg::REG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // config registers; to be written only while the block is idle, which the block itself does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_side     <= 1'b0;
      cfg_q.front_pair    <= 1'b0;
      cfg_q.edge_mount    <= 1'b0;
      cfg_q.upper_link_cm <= lik_pkg::UPPER_LINK_RST;
      cfg_q.lower_link_cm <= lik_pkg::LOWER_LINK_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lik_pkg::REG_LEFT_SIDE:  cfg_q.left_side     <= pwdata[0];
        lik_pkg::REG_FRONT_PAIR: cfg_q.front_pair    <= pwdata[0];
        lik_pkg::REG_EDGE_MOUNT: cfg_q.edge_mount    <= pwdata[0];
        lik_pkg::REG_UPPER_LINK: cfg_q.upper_link_cm <= pwdata[lik_pkg::LINK_W-1:0];
        lik_pkg::REG_LOWER_LINK: cfg_q.lower_link_cm <= pwdata[lik_pkg::LINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lik_pkg::REG_LEFT_SIDE:  prdata = 32'(cfg_q.left_side);
      lik_pkg::REG_FRONT_PAIR: prdata = 32'(cfg_q.front_pair);
      lik_pkg::REG_EDGE_MOUNT: prdata = 32'(cfg_q.edge_mount);
      lik_pkg::REG_UPPER_LINK: prdata = 32'(cfg_q.upper_link_cm);
      lik_pkg::REG_LOWER_LINK: prdata = 32'(cfg_q.lower_link_cm);
      default:                 prdata = '0;
    endcase
  end

  lik_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lik_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

  // an accepted beat must take the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer stayed idle after accepting a beat");

  a_hip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hip_valid |-> out_data_o.hip_angle == 8'd0)
    else $error("hip angle set without hip_valid");

  a_joints_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.joints_valid |->
      out_data_o.knee_angle == 8'd0 && out_data_o.foot_angle == 8'd0)
    else $error("joint angles set without joints_valid");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hip_angle <= 8'd180 &&
      out_data_o.knee_angle <= 8'd180 && out_data_o.foot_angle <= 8'd180)
    else $error("angle above 180 degrees");

endmodule

`default_nettype wire

// File: hw/rtl/lik_cordic.sv
// Iterative atan2 unit: normalize shift, then 20 CORDIC vectoring steps; zero inputs are answered directly.
// Depends on lik_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module lik_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lik_pkg::MAG_W-1:0]         y_i,
  input  logic [lik_pkg::MAG_W-1:0]         x_i,
  input  logic                              neg_i,   // x was negative: 180 - angle
  output logic                              busy_o,
  output logic signed [lik_pkg::ANG_W-1:0]  angle_o
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_NORM = 2'd1;
  localparam logic [1:0] P_ITER = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [4:0] cnt_q, cnt_d;
  logic signed [lik_pkg::CORD_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [lik_pkg::ANG_W-1:0]  z_q, z_d, angle_q, angle_d;
  logic neg_q, neg_d;

  logic signed [lik_pkg::CORD_W-1:0] sx, sy;
  logic signed [lik_pkg::ANG_W-1:0]  step, zc;
  logic norm_room;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    neg_d     = neg_q;
    angle_d   = angle_q;
    sx        = y_q >>> cnt_q;
    sy        = x_q >>> cnt_q;
    step      = lik_pkg::ANG_W'(lik_pkg::atan_deg(cnt_q));
    norm_room = (x_q[lik_pkg::CORD_W-1:lik_pkg::NORM_BIT] == '0) &&
                (y_q[lik_pkg::CORD_W-1:lik_pkg::NORM_BIT] == '0);
    zc        = '0;
    case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          if (y_i == '0) begin
            angle_d = neg_i ? lik_pkg::ANG_180 : '0;
          end else if (x_i == '0) begin
            angle_d = lik_pkg::ANG_90;
          end else begin
            x_d     = lik_pkg::CORD_W'(x_i);
            y_d     = lik_pkg::CORD_W'(y_i);
            z_d     = '0;
            neg_d   = neg_i;
            phase_d = P_NORM;
          end
        end
      end
      P_NORM: begin
        if (norm_room) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          cnt_d   = '0;
          phase_d = P_ITER;
        end
      end
      P_ITER: begin
        if (!y_q[lik_pkg::CORD_W-1]) begin
          x_d = x_q + sx;
          y_d = y_q - sy;
          z_d = z_q + step;
        end else begin
          x_d = x_q - sx;
          y_d = y_q + sy;
          z_d = z_q - step;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(lik_pkg::CORDIC_STEPS - 1)) begin
          if (z_d[lik_pkg::ANG_W-1]) begin
            zc = '0;
          end else if (z_d > lik_pkg::ANG_90) begin
            zc = lik_pkg::ANG_90;
          end else begin
            zc = z_d;
          end
          angle_d = neg_q ? (lik_pkg::ANG_180 - zc) : zc;
          phase_d = P_IDLE;
        end
      end
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    neg_q   <= neg_d;
    angle_q <= angle_d;
  end

  assign busy_o  = (phase_q != P_IDLE);
  assign angle_o = angle_q;

endmodule

`default_nettype wire

// File: hw/rtl/lik_isqrt.sv
// Bit-pair integer square root, one result bit per cycle.
// Depends on lik_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module lik_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lik_pkg::SQRT_W-1:0]   n_i,
  output logic                         busy_o,
  output logic [lik_pkg::ROOT_W-1:0]   root_o
);

  logic [lik_pkg::SQRT_W-1:0] bit_q, n_q, res_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= lik_pkg::SQRT_W'(1) << (lik_pkg::SQRT_W - 2);
    end else begin
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign busy_o = (bit_q != '0);
  assign root_o = res_q[lik_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/lik_datapath.sv
// Datapath: origin store, shared 32x32 multiplier, root and angle units,
// result and output registers. Depends on lik_pkg, lik_cordic, lik_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module lik_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lik_pkg::cmd_t       cmd_i,
  input  lik_pkg::cfg_t       cfg_i,
  input  lik_pkg::in_item_t   in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output lik_pkg::out_item_t  out_data_o,
  output lik_pkg::status_t    status_o
);

  localparam int CW  = lik_pkg::COORD_W;
  localparam int MW  = lik_pkg::MAG_W;
  localparam int AW  = lik_pkg::ANG_W;

  localparam logic signed [CW:0] ZMAX = (CW+1)'((1 << (CW - 1)) - 1);

  logic signed [CW-1:0] origin_x_q, origin_y_q, origin_z_q;
  lik_pkg::in_item_t    item_q;
  logic [MW-1:0]        adx_q, ady_q, h_q;
  logic                 ahead_q, above_q, reach_q, hip_nz_q;
  logic [31:0]          sxx_q, syy_q, shh_q, lim2_q;
  logic [33:0]          s_q;
  logic [32:0]          sxy_q;
  logic signed [31:0]   cb_q, cv_q;
  logic signed [63:0]   m4_q, m5_q, d_q;
  logic [31:0]          r_q, horiz_q;
  logic signed [AW-1:0] b_q, v_q;
  lik_pkg::out_item_t   res_q, out_q;
  logic                 out_valid_q;

  // link terms
  logic [lik_pkg::LINK_W:0] link_sum;
  logic [14:0]              lim;
  logic [11:0]              l1s, l2s;
  assign link_sum = (lik_pkg::LINK_W+1)'(cfg_i.upper_link_cm) +
                    (lik_pkg::LINK_W+1)'(cfg_i.lower_link_cm);
  assign lim      = {link_sum, 8'b0};
  assign l1s      = 12'(cfg_i.upper_link_cm) * 12'(cfg_i.lower_link_cm == '0 ?
                    cfg_i.upper_link_cm : cfg_i.upper_link_cm);
  assign l2s      = 12'(cfg_i.lower_link_cm) * 12'(cfg_i.lower_link_cm);

  // differences against the origin
  logic signed [CW:0] dx, dy, dz, zs;
  logic [CW:0]        adx, ady, adz;
  assign dx  = (CW+1)'(item_q.coord_x) - (CW+1)'(origin_x_q);
  assign dy  = (CW+1)'(item_q.coord_y) - (CW+1)'(origin_y_q);
  assign dz  = (CW+1)'(origin_z_q) - (CW+1)'(item_q.coord_z);
  assign adx = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
  assign ady = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
  assign adz = dz[CW] ? $unsigned(-dz) : $unsigned(dz);
  assign zs  = (CW+1)'(item_q.coord_z) + (CW+1)'(lik_pkg::HEIGHT_RAISE);

  // shared multiplier, product registered into its destination
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      lik_pkg::CMD_MUL_XX: begin
        mul_a = $signed(adx_q[31:0]);
        mul_b = $signed(adx_q[31:0]);
      end
      lik_pkg::CMD_MUL_YY: begin
        mul_a = $signed(ady_q[31:0]);
        mul_b = $signed(ady_q[31:0]);
      end
      lik_pkg::CMD_MUL_HH: begin
        mul_a = $signed(h_q[31:0]);
        mul_b = $signed(h_q[31:0]);
      end
      lik_pkg::CMD_MUL_LIM: begin
        mul_a = $signed(32'(lim));
        mul_b = $signed(32'(lim));
      end
      lik_pkg::CMD_MUL_D1: begin
        mul_a = $signed(s_q[31:0]);
        mul_b = $signed(32'({l1s, 2'b00}));
      end
      lik_pkg::CMD_MUL_D2: begin
        mul_a = cv_q;
        mul_b = cv_q;
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // cb / cv
  logic signed [39:0] ls40, ld40, s40;
  assign ls40 = 40'(13'(l1s) + 13'(l2s)) <<< 16;
  assign ld40 = (40'(l1s) - 40'(l2s)) <<< 16;
  assign s40  = 40'(s_q);

  // angle unit operand select
  logic signed [32:0] cb_ext, cv_ext, cb_abs, cv_abs;
  logic [MW-1:0]      cord_y, cord_x, hq;
  logic               cord_neg, cord_start, cord_busy;
  logic signed [AW-1:0] cord_angle;
  assign cb_ext = 33'(cb_q);
  assign cv_ext = 33'(cv_q);
  assign cb_abs = cb_ext[32] ? -cb_ext : cb_ext;
  assign cv_abs = cv_ext[32] ? -cv_ext : cv_ext;
  assign hq     = {h_q[MW-9:0], 8'b0};

  always_comb begin
    cord_y     = '0;
    cord_x     = '0;
    cord_neg   = 1'b0;
    cord_start = 1'b1;
    case (cmd_i.op)
      lik_pkg::CMD_CORD_HIP: begin
        cord_y = ady_q;
        cord_x = adx_q;
      end
      lik_pkg::CMD_CORD_B: begin
        cord_y   = MW'(r_q);
        cord_x   = MW'($unsigned(cb_abs));
        cord_neg = cb_q[31];
      end
      lik_pkg::CMD_CORD_V: begin
        cord_y   = MW'(r_q);
        cord_x   = MW'($unsigned(cv_abs));
        cord_neg = cv_q[31];
      end
      lik_pkg::CMD_CORD_P: begin
        cord_y = above_q ? MW'(horiz_q) : hq;
        cord_x = above_q ? hq : MW'(horiz_q);
      end
      default: cord_start = 1'b0;
    endcase
  end

  lik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (cord_y),
    .x_i     (cord_x),
    .neg_i   (cord_neg),
    .busy_o  (cord_busy),
    .angle_o (cord_angle)
  );

  logic                       sqrt_start, sqrt_busy;
  logic [lik_pkg::SQRT_W-1:0] sqrt_n;
  logic [lik_pkg::ROOT_W-1:0] sqrt_root;
  assign sqrt_start = (cmd_i.op == lik_pkg::CMD_SQRT_D) || (cmd_i.op == lik_pkg::CMD_SQRT_H);
  assign sqrt_n     = (cmd_i.op == lik_pkg::CMD_SQRT_D) ? $unsigned(d_q)
                                                       : (64'(sxy_q) << 16);

  lik_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .n_i     (sqrt_n),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  // hip angle from the horizontal offset
  logic signed [AW-1:0] off, hip_val, knee_a;
  assign off = cfg_i.front_pair ? lik_pkg::OFF_57 : lik_pkg::OFF_61;
  always_comb begin
    if (!cfg_i.edge_mount) begin
      hip_val = (cfg_i.left_side ? ahead_q : !ahead_q) ?
                (lik_pkg::ANG_180 - cord_angle) : cord_angle;
    end else if (cfg_i.left_side) begin
      if (ahead_q) begin
        hip_val = cfg_i.front_pair ? (lik_pkg::ANG_180 - off - cord_angle)
                                   : (lik_pkg::ANG_180 + off - cord_angle);
      end else begin
        hip_val = cfg_i.front_pair ? (cord_angle - off) : (cord_angle + off);
      end
    end else begin
      if (ahead_q) begin
        hip_val = cfg_i.front_pair ? (cord_angle + off) : (cord_angle - off);
      end else begin
        hip_val = cfg_i.front_pair ? (lik_pkg::ANG_180 + off - cord_angle)
                                   : (lik_pkg::ANG_180 - off - cord_angle);
      end
    end
  end

  // knee angle, p is the angle unit result at finish
  assign knee_a = above_q ? (lik_pkg::ANG_180 - v_q - cord_angle)
                          : (lik_pkg::ANG_90 - v_q - cord_angle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      origin_z_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == lik_pkg::CMD_SET) begin
        origin_x_q <= item_q.coord_x;
        origin_y_q <= item_q.coord_y;
        origin_z_q <= (zs > ZMAX) ? ZMAX[CW-1:0] : zs[CW-1:0];
      end
      if (cmd_i.op == lik_pkg::CMD_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lik_pkg::CMD_LOAD: item_q <= in_data_i;
      lik_pkg::CMD_DIFF: begin
        adx_q   <= MW'(adx);
        ady_q   <= MW'(ady);
        h_q     <= MW'(adz);
        ahead_q <= (item_q.coord_x >= origin_x_q);
        above_q <= (origin_z_q >= item_q.coord_z);
        res_q   <= '0;
      end
      lik_pkg::CMD_CHECK: begin
        hip_nz_q <= (adx_q != '0) || (ady_q != '0);
        reach_q  <= (cfg_i.upper_link_cm != '0) && (cfg_i.lower_link_cm != '0) &&
                    (adx_q <= MW'(lim)) && (ady_q <= MW'(lim)) && (h_q <= MW'(lim));
      end
      lik_pkg::CMD_GET_HIP: begin
        res_q.hip_angle <= lik_pkg::whole_deg(hip_val);
        res_q.hip_valid <= 1'b1;
      end
      lik_pkg::CMD_MUL_XX:  sxx_q  <= prod[31:0];
      lik_pkg::CMD_MUL_YY:  syy_q  <= prod[31:0];
      lik_pkg::CMD_MUL_HH:  shh_q  <= prod[31:0];
      lik_pkg::CMD_MUL_LIM: lim2_q <= prod[31:0];
      lik_pkg::CMD_SUM: begin
        s_q   <= 34'(sxx_q) + 34'(syy_q) + 34'(shh_q);
        sxy_q <= 33'(sxx_q) + 33'(syy_q);
      end
      lik_pkg::CMD_PREP: begin
        cb_q <= 32'(ls40 - s40);
        cv_q <= 32'(s40 + ld40);
      end
      lik_pkg::CMD_MUL_D1: m4_q <= prod;
      lik_pkg::CMD_MUL_D2: m5_q <= prod;
      lik_pkg::CMD_DIFF_D: d_q  <= (m4_q <<< 16) - m5_q;
      lik_pkg::CMD_GET_R:  r_q  <= sqrt_root;
      lik_pkg::CMD_GET_H:  horiz_q <= sqrt_root;
      lik_pkg::CMD_GET_B:  b_q  <= cord_angle;
      lik_pkg::CMD_GET_V:  v_q  <= cord_angle;
      lik_pkg::CMD_FINISH: begin
        if (!knee_a[AW-1] && (knee_a <= lik_pkg::ANG_180)) begin
          res_q.joints_valid <= 1'b1;
          if (cfg_i.left_side) begin
            res_q.knee_angle <= lik_pkg::whole_deg(lik_pkg::ANG_180 - knee_a);
            res_q.foot_angle <= lik_pkg::whole_deg(lik_pkg::ANG_180 - b_q);
          end else begin
            res_q.knee_angle <= lik_pkg::whole_deg(knee_a);
            res_q.foot_angle <= lik_pkg::whole_deg(b_q);
          end
        end
      end
      lik_pkg::CMD_PUSH: out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.is_move   = item_q.operation;
  assign status_o.hip_nz    = hip_nz_q;
  assign status_o.reach     = reach_q;
  assign status_o.s_ok      = (s_q != '0) && (s_q <= 34'(lim2_q));
  assign status_o.d_ok      = !d_q[63];
  assign status_o.cord_busy = cord_busy;
  assign status_o.sqrt_busy = sqrt_busy;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: hw/rtl/lik_ctrl.sv
// Sequencer: walks one item through the datapath, one command per cycle.
// Depends on lik_pkg for command codes and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module lik_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  lik_pkg::status_t status_i,
  output logic             in_ready_o,
  output lik_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_HIPS  = 5'd3;
  localparam logic [4:0] S_HIPW  = 5'd4;
  localparam logic [4:0] S_REACH = 5'd5;
  localparam logic [4:0] S_MYY   = 5'd6;
  localparam logic [4:0] S_MHH   = 5'd7;
  localparam logic [4:0] S_MLIM  = 5'd8;
  localparam logic [4:0] S_SUM   = 5'd9;
  localparam logic [4:0] S_SCHK  = 5'd10;
  localparam logic [4:0] S_MD1   = 5'd11;
  localparam logic [4:0] S_MD2   = 5'd12;
  localparam logic [4:0] S_DIFD  = 5'd13;
  localparam logic [4:0] S_DCHK  = 5'd14;
  localparam logic [4:0] S_SQDW  = 5'd15;
  localparam logic [4:0] S_SQHS  = 5'd16;
  localparam logic [4:0] S_SQHW  = 5'd17;
  localparam logic [4:0] S_CBS   = 5'd18;
  localparam logic [4:0] S_CBW   = 5'd19;
  localparam logic [4:0] S_CVS   = 5'd20;
  localparam logic [4:0] S_CVW   = 5'd21;
  localparam logic [4:0] S_CPS   = 5'd22;
  localparam logic [4:0] S_CPW   = 5'd23;
  localparam logic [4:0] S_FIN   = 5'd24;
  localparam logic [4:0] S_EMIT  = 5'd25;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o.op = lik_pkg::CMD_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = lik_pkg::CMD_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        if (status_i.is_move) begin
          cmd_o.op = lik_pkg::CMD_DIFF;
          state_d  = S_CHK;
        end else begin
          cmd_o.op = lik_pkg::CMD_SET;
          state_d  = S_IDLE;
        end
      end
      S_CHK: begin
        cmd_o.op = lik_pkg::CMD_CHECK;
        state_d  = S_HIPS;
      end
      S_HIPS: begin
        if (status_i.hip_nz) begin
          cmd_o.op = lik_pkg::CMD_CORD_HIP;
          state_d  = S_HIPW;
        end else begin
          state_d = S_REACH;
        end
      end
      S_HIPW: begin
        if (!status_i.cord_busy) begin
          cmd_o.op = lik_pkg::CMD_GET_HIP;
          state_d  = S_REACH;
        end
      end
      S_REACH: begin
        if (status_i.reach) begin
          cmd_o.op = lik_pkg::CMD_MUL_XX;
          state_d  = S_MYY;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_MYY: begin
        cmd_o.op = lik_pkg::CMD_MUL_YY;
        state_d  = S_MHH;
      end
      S_MHH: begin
        cmd_o.op = lik_pkg::CMD_MUL_HH;
        state_d  = S_MLIM;
      end
      S_MLIM: begin
        cmd_o.op = lik_pkg::CMD_MUL_LIM;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = lik_pkg::CMD_SUM;
        state_d  = S_SCHK;
      end
      S_SCHK: begin
        if (status_i.s_ok) begin
          cmd_o.op = lik_pkg::CMD_PREP;
          state_d  = S_MD1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_MD1: begin
        cmd_o.op = lik_pkg::CMD_MUL_D1;
        state_d  = S_MD2;
      end
      S_MD2: begin
        cmd_o.op = lik_pkg::CMD_MUL_D2;
        state_d  = S_DIFD;
      end
      S_DIFD: begin
        cmd_o.op = lik_pkg::CMD_DIFF_D;
        state_d  = S_DCHK;
      end
      S_DCHK: begin
        if (status_i.d_ok) begin
          cmd_o.op = lik_pkg::CMD_SQRT_D;
          state_d  = S_SQDW;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SQDW: begin
        if (!status_i.sqrt_busy) begin
          cmd_o.op = lik_pkg::CMD_GET_R;
          state_d  = S_SQHS;
        end
      end
      S_SQHS: begin
        cmd_o.op = lik_pkg::CMD_SQRT_H;
        state_d  = S_SQHW;
      end
      S_SQHW: begin
        if (!status_i.sqrt_busy) begin
          cmd_o.op = lik_pkg::CMD_GET_H;
          state_d  = S_CBS;
        end
      end
      S_CBS: begin
        cmd_o.op = lik_pkg::CMD_CORD_B;
        state_d  = S_CBW;
      end
      S_CBW: begin
        if (!status_i.cord_busy) begin
          cmd_o.op = lik_pkg::CMD_GET_B;
          state_d  = S_CVS;
        end
      end
      S_CVS: begin
        cmd_o.op = lik_pkg::CMD_CORD_V;
        state_d  = S_CVW;
      end
      S_CVW: begin
        if (!status_i.cord_busy) begin
          cmd_o.op = lik_pkg::CMD_GET_V;
          state_d  = S_CPS;
        end
      end
      S_CPS: begin
        cmd_o.op = lik_pkg::CMD_CORD_P;
        state_d  = S_CPW;
      end
      S_CPW: begin
        // p is read straight off the angle unit at finish
        if (!status_i.cord_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = lik_pkg::CMD_FINISH;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = lik_pkg::CMD_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

// File: tb/sv/leg_inverse_kinematics_test.sv
// Self-checking testbench for leg_inverse_kinematics: set/move beats, APB register phases.
// Depends on lik_pkg and the leg_inverse_kinematics RTL; a scoreboard class predicts angles.
`timescale 1ns / 1ps

module leg_inverse_kinematics_test;

  localparam longint DEG      = 65536;
  localparam longint FULL     = 180 * DEG;
  localparam longint NORM_LIM = 64'sd1 << 40;
  localparam int     DRAIN    = 400;    // longer than the slowest move path
  localparam int     WD_LIMIT = 5000;   // cycles without any accepted beat
  localparam logic   OP_SET   = 1'b0;
  localparam logic   OP_MOVE  = 1'b1;

  // Scoreboard: keeps its own copy of origin and registers, predicts one result per move.
  class ik_scoreboard;
    bit                 left_side, front_pair, edge_mount;
    int                 upper_cm, lower_cm;
    longint             org_x, org_y, org_z;
    lik_pkg::out_item_t pending_angles[$];
    int                 mismatches;

    function new();
      left_side = 0; front_pair = 0; edge_mount = 0;
      upper_cm = 9; lower_cm = 16;
      org_x = 0; org_y = 0; org_z = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [lik_pkg::REG_IDX_W-1:0] idx, int val);
      case (idx)
        lik_pkg::REG_LEFT_SIDE:  left_side  = val[0];
        lik_pkg::REG_FRONT_PAIR: front_pair = val[0];
        lik_pkg::REG_EDGE_MOUNT: edge_mount = val[0];
        lik_pkg::REG_UPPER_LINK: upper_cm   = val & 63;
        lik_pkg::REG_LOWER_LINK: lower_cm   = val & 63;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // first-quadrant atan2 in Q16 degrees, same CORDIC recipe as the datapath
    function longint atan_q1(longint y, longint x);
      longint z, sx, sy;
      z = 0;
      if (y == 0) return 0;
      if (x == 0) return 90 * DEG;
      while (x < NORM_LIM && y < NORM_LIM) begin
        x = x * 2;
        y = y * 2;
      end
      for (int i = 0; i < lik_pkg::CORDIC_STEPS; i++) begin
        sx = y >>> i;
        sy = x >>> i;
        if (y >= 0) begin
          x += sx; y -= sy; z += longint'(lik_pkg::atan_deg(i[4:0]));
        end else begin
          x -= sx; y += sy; z -= longint'(lik_pkg::atan_deg(i[4:0]));
        end
      end
      if (z < 0) z = 0;
      if (z > 90 * DEG) z = 90 * DEG;
      return z;
    endfunction

    function longint atan_half(longint y, longint x);
      if (x < 0) return FULL - atan_q1(y, -x);
      return atan_q1(y, x);
    endfunction

    function logic [7:0] to_degrees(longint a);
      longint q;
      if (a < 0) return 8'd0;
      q = a / DEG;
      return (q > 180) ? 8'd180 : q[7:0];
    endfunction

    function void note_input(lik_pkg::in_item_t it);
      longint cx, cy, cz, dx, dy, adx, ady, h, lim, a, val, off, l1, l2;
      longint s_sum, l1s, l2s, cb, cv, disc, r, b, v, p, horiz, hq, zsum;
      bit ahead;
      lik_pkg::out_item_t res;
      cx = it.coord_x; cy = it.coord_y; cz = it.coord_z;
      if (it.operation == OP_SET) begin
        zsum = cz + 1024;
        org_x = cx; org_y = cy;
        org_z = (zsum > 32767) ? 32767 : zsum;   // height raise saturates
        return;
      end
      res = '0;
      l1 = upper_cm; l2 = lower_cm;
      dx = cx - org_x; dy = cy - org_y;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      h = org_z - cz;
      if (h < 0) h = -h;
      if (adx != 0 || ady != 0) begin
        a = atan_q1(ady, adx);
        ahead = cx >= org_x;
        off = (front_pair ? 57 : 61) * DEG;
        if (!edge_mount) val = (left_side ? ahead : !ahead) ? FULL - a : a;
        else if (left_side) begin
          if (ahead) val = front_pair ? FULL - off - a : FULL + off - a;
          else       val = front_pair ? a - off : a + off;
        end else begin
          if (ahead) val = front_pair ? a + off : a - off;
          else       val = front_pair ? FULL + off - a : FULL - off - a;
        end
        res.hip_angle = to_degrees(val);
        res.hip_valid = 1'b1;
      end
      lim = (l1 + l2) << 8;
      if (l1 != 0 && l2 != 0 && adx <= lim && ady <= lim && h <= lim) begin
        s_sum = adx * adx + ady * ady + h * h;
        if (s_sum > 0 && s_sum <= lim * lim) begin
          l1s = l1 * l1; l2s = l2 * l2;
          cb = (l1s + l2s) * DEG - s_sum;
          cv = s_sum + (l1s - l2s) * DEG;
          disc = 4 * l1s * s_sum * DEG - cv * cv;
          if (disc >= 0) begin
            r = int_sqrt(disc);
            b = atan_half(r, cb);
            v = atan_half(r, cv);
            horiz = int_sqrt((adx * adx + ady * ady) << 16);
            hq = h << 8;
            if (org_z >= cz) begin
              p = atan_half(horiz, hq);
              a = FULL - v - p;
            end else begin
              p = atan_half(hq, horiz);
              a = 90 * DEG - v - p;   // target above the origin
            end
            if (a >= 0 && a <= FULL) begin
              res.joints_valid = 1'b1;
              res.knee_angle = to_degrees(left_side ? FULL - a : a);
              res.foot_angle = to_degrees(left_side ? FULL - b : b);
            end
          end
        end
      end
      pending_angles.push_back(res);
    endfunction

    function void check_result(lik_pkg::out_item_t got);
      lik_pkg::out_item_t want;
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending_angles.pop_front();
      if (got.hip_angle !== want.hip_angle || got.hip_valid !== want.hip_valid ||
          got.knee_angle !== want.knee_angle || got.foot_angle !== want.foot_angle ||
          got.joints_valid !== want.joints_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected hip %0d/%0b knee %0d foot %0d jv %0b,",
                    " got hip %0d/%0b knee %0d foot %0d jv %0b"},
                   want.hip_angle, want.hip_valid, want.knee_angle, want.foot_angle,
                   want.joints_valid, got.hip_angle, got.hip_valid, got.knee_angle,
                   got.foot_angle, got.joints_valid);
      end
    endfunction
  endclass

  logic                           clk_i, rst_ni;
  logic                           psel, penable, pwrite;
  logic [lik_pkg::REG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata, prdata;
  logic                           pready;
  logic                           in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  lik_pkg::in_item_t              in_data_i;
  lik_pkg::out_item_t             out_data_o;

  ik_scoreboard angle_board = new();
  bit quiet_tail;       // no idling on either side near the end
  int idle_cycles;

  leg_inverse_kinematics u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver: ready in random bursts, with random stalls between them
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  end

  // result beats and the watchdog on lack of progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) angle_board.check_result(out_data_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [lik_pkg::REG_IDX_W-1:0] idx, int val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // register takes the value at this edge
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    angle_board.write_reg(idx, val);
  endtask

  // one input beat, sometimes after a random gap; valid is otherwise held across back-to-back beats
  task automatic send_beat(logic op, int x, int y, int z);
    lik_pkg::in_item_t it;
    it.operation = op;
    it.coord_x = x[15:0]; it.coord_y = y[15:0]; it.coord_z = z[15:0];
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    angle_board.note_input(it);
  endtask

  task automatic drain_results();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (angle_board.pending_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  // a set beat followed by a few moves near the origin, scaled to the reach
  task automatic reachable_run();
    int reach, span, ox, oy, oz, k, scale;
    reach = (angle_board.upper_cm + angle_board.lower_cm) * 256;
    span  = (32767 - reach > 0) ? 32767 - reach : 0;
    ox = $urandom_range(0, 2 * span) - span;
    oy = $urandom_range(0, 2 * span) - span;
    oz = $urandom_range(0, 2 * span) - span;
    send_beat(OP_SET, ox, oy, oz);
    k = $urandom_range(1, 6);
    repeat (k) begin
      scale = $urandom_range(1, 4);
      send_beat(OP_MOVE,
                clamp16(ox + (int'($urandom_range(0, 2 * reach)) - reach) / scale),
                clamp16(oy + (int'($urandom_range(0, 2 * reach)) - reach) / scale),
                clamp16(oz + 1024 + (int'($urandom_range(0, 2 * reach)) - reach) / scale));
    end
  endtask

  task automatic random_phase(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) != 0) begin
        reachable_run();
        sent += 4;
      end else begin
        send_beat($urandom_range(0, 1), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
        sent++;
      end
    end
  endtask

  task automatic load_config(bit ls, bit fp, bit em, int up, int lo);
    reg_write(lik_pkg::REG_LEFT_SIDE, ls);
    reg_write(lik_pkg::REG_FRONT_PAIR, fp);
    reg_write(lik_pkg::REG_EDGE_MOUNT, em);
    reg_write(lik_pkg::REG_UPPER_LINK, up);
    reg_write(lik_pkg::REG_LOWER_LINK, lo);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; in_data_i = '0;
    quiet_tail = 1'b0; idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset links 9/16, origin starts at zero
    send_beat(OP_MOVE, 0, 0, 0);             // zero offset, zero distance
    send_beat(OP_MOVE, 0, 0, -4000);         // straight down, no hip
    send_beat(OP_MOVE, 2000, 1500, -3000);   // foot below
    send_beat(OP_MOVE, -2000, 1500, 2000);   // foot above, behind
    send_beat(OP_MOVE, 32767, 32767, 32767);
    send_beat(OP_MOVE, -32768, -32768, -32768);
    send_beat(OP_SET, 100, -200, 32767);     // height raise saturates
    send_beat(OP_MOVE, 100, -200, 32767);    // target on the saturated origin
    send_beat(OP_SET, -32768, 32767, -32768);
    send_beat(OP_MOVE, -32768 + 3000, 32767, -32768 + 1024);
    send_beat(OP_MOVE, -32768, 32767 - 6400, -32768 + 1024);  // full stretch
    send_beat(OP_SET, 0, 0, -1024);
    send_beat(OP_MOVE, 400, 0, 0);           // too close for the links
    send_beat(OP_MOVE, 6400, 0, 0);          // exactly at full reach
    send_beat(OP_MOVE, -6401, 0, 0);         // just beyond reach
    send_beat(OP_MOVE, 3000, -3000, 1500);
    drain_results();

    // phases over the register space, extremes included
    load_config(0, 0, 0, 9, 16);   random_phase(180);
    drain_results();
    load_config(1, 0, 0, 9, 16);   random_phase(180);
    // sender holds off until every result is in, then resumes mid phase
    drain_results();
    random_phase(40);
    drain_results();
    load_config(0, 1, 1, 20, 30);  random_phase(180);
    drain_results();
    load_config(1, 0, 1, 12, 12);  random_phase(180);
    drain_results();
    load_config(1, 1, 1, 63, 63);  random_phase(180);
    drain_results();
    load_config(0, 0, 1, 1, 1);    random_phase(180);
    drain_results();
    load_config(0, 1, 0, 63, 1);   random_phase(180);
    drain_results();
    load_config($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(1, 63), $urandom_range(1, 63));
    random_phase(180);
    drain_results();
    load_config(1, 1, 0, 1, 63);
    quiet_tail = 1'b1;
    random_phase(160);
    drain_results();

    if (angle_board.mismatches == 0 && angle_board.pending_angles.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
